// ===== rtl/core/abwd_pkg.sv =====
// ----------------------------------------------------------------------------
// abwd_pkg
// Shared types and constants for the ADC bank word decoder.
// ----------------------------------------------------------------------------
package abwd_pkg;

  localparam int NumBoardsDefault        = 16;
  localparam int PayloadCountBitsDefault = 20;
  localparam int NumBankNamesDefault     = 6;
  localparam int MaxBankNames            = 7;

  // Bank names, four ASCII characters packed little-endian.
  localparam logic [31:0] BANK_NAMES [MaxBankNames] = '{
    32'h5F41_4349,  // "ICA_"
    32'h4132_4453,  // "SD2A"
    32'h4131_4453,  // "SD1A"
    32'h5F41_4459,  // "YDA_"
    32'h5F41_5553,  // "SUA_"
    32'h5F41_5559,  // "YUA_"
    32'h4152_5456   // "VTRA"
  };

  // Payload word kind, word bits 31:30.
  localparam logic [1:0] KIND_DATA    = 2'b00;
  localparam logic [1:0] KIND_HEADER  = 2'b01;

  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_SIZE    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last_word;
  } word_t;

  typedef struct packed {
    logic       hit_valid;
    logic [2:0] bank_index;
    logic       board_known;
    logic [7:0] board_id;
    logic [4:0] channel;
    logic [7:0] sample_value;
    logic       event_end;
    logic       boards_complete;
    logic       duplicate_board;
    logic       board_out_of_range;
  } result_t;

  // Bank tracking state of fixed width.
  typedef struct packed {
    phase_t     phase;
    logic [2:0] current_bank;
    logic [7:0] latest_board;
    logic       latest_board_known;
  } bank_state_t;

endpackage

// ===== rtl/core/adc_bank_word_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// adc_bank_word_decoder_unit
// Decodes event-body words into ADC hits and board bookkeeping flags.
// ----------------------------------------------------------------------------
// Datapath: an accepted word is held in the input register, then decoded
//   straight into the result register, which drives result_valid.
// Throughput: one word per cycle while the consumer keeps result_ready high;
//   words that give no result never wait on the result register.
// Reset (rst, synchronous): bank state, payload count and board mask clear,
//   both register stages empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module adc_bank_word_decoder_unit #(
  parameter int NUM_BOARDS         = abwd_pkg::NumBoardsDefault,
  parameter int PAYLOAD_COUNT_BITS = abwd_pkg::PayloadCountBitsDefault,
  parameter int NUM_BANK_NAMES     = abwd_pkg::NumBankNamesDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              word_valid,
  output logic              word_ready,
  input  abwd_pkg::word_t   word_data,
  output logic              result_valid,
  input  logic              result_ready,
  output abwd_pkg::result_t result_data
);

  // Input register stage.
  logic                  in_full;
  abwd_pkg::word_t       in_item;

  // Decoder state.
  abwd_pkg::bank_state_t         state;
  abwd_pkg::bank_state_t         state_next;
  logic [PAYLOAD_COUNT_BITS-1:0] payload_left;
  logic [PAYLOAD_COUNT_BITS-1:0] payload_left_next;
  logic [NUM_BOARDS-1:0]         seen_boards;
  logic [NUM_BOARDS-1:0]         seen_boards_next;

  logic                  emit;
  abwd_pkg::result_t     dec_result;
  logic                  out_free;
  logic                  advance;

  // The held word is decoded and retired once its result (if any) has room.
  assign advance    = in_full && (!emit || out_free);
  assign word_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (word_ready) begin
      in_full <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready && word_valid) begin
      in_item <= word_data;
    end
  end

  // Bank state moves only when the held word retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase              <= abwd_pkg::PH_SCAN;
      state.current_bank       <= '0;
      state.latest_board       <= '0;
      state.latest_board_known <= 1'b0;
      payload_left             <= '0;
      seen_boards              <= '0;
    end else if (advance) begin
      state        <= state_next;
      payload_left <= payload_left_next;
      seen_boards  <= seen_boards_next;
    end
  end

  abwd_decode #(
    .NUM_BOARDS         (NUM_BOARDS),
    .PAYLOAD_COUNT_BITS (PAYLOAD_COUNT_BITS),
    .NUM_BANK_NAMES     (NUM_BANK_NAMES)
  ) u_decode (
    .item              (in_item),
    .state             (state),
    .payload_left      (payload_left),
    .seen_boards       (seen_boards),
    .state_next        (state_next),
    .payload_left_next (payload_left_next),
    .seen_boards_next  (seen_boards_next),
    .emit              (emit),
    .result            (dec_result)
  );

  // Result register decouples the consumer from the decode stage.
  abwd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && emit),
    .load_data    (dec_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

// ===== rtl/core/abwd_decode.sv =====
// ----------------------------------------------------------------------------
// abwd_decode
// Single-pass decode of one event word against the current bank state.
// ----------------------------------------------------------------------------
module abwd_decode #(
  parameter int NUM_BOARDS         = abwd_pkg::NumBoardsDefault,
  parameter int PAYLOAD_COUNT_BITS = abwd_pkg::PayloadCountBitsDefault,
  parameter int NUM_BANK_NAMES     = abwd_pkg::NumBankNamesDefault
) (
  input  abwd_pkg::word_t               item,
  input  abwd_pkg::bank_state_t         state,
  input  logic [PAYLOAD_COUNT_BITS-1:0] payload_left,
  input  logic [NUM_BOARDS-1:0]         seen_boards,
  output abwd_pkg::bank_state_t         state_next,
  output logic [PAYLOAD_COUNT_BITS-1:0] payload_left_next,
  output logic [NUM_BOARDS-1:0]         seen_boards_next,
  output logic                          emit,
  output abwd_pkg::result_t             result
);

  localparam logic [30:0] CountMax = 31'((64'(1) << PAYLOAD_COUNT_BITS) - 64'(1));

  abwd_pkg::bank_state_t         st;
  logic [PAYLOAD_COUNT_BITS-1:0] left;
  logic [NUM_BOARDS-1:0]         seen;
  logic [NUM_BOARDS-1:0]         board_hot;
  logic                          found;
  logic [2:0]                    found_idx;
  logic [29:0]                   size_words;
  logic [7:0]                    board;
  logic                          hit;
  logic                          dup;
  logic                          oor;
  logic                          show_bank;

  assign size_words = item.word[31:2];
  assign board      = item.word[23:16];

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = 0; j < NUM_BANK_NAMES; j++) begin
      if (!found && item.word == abwd_pkg::BANK_NAMES[j]) begin
        found     = 1'b1;
        found_idx = 3'(j);
      end
    end
    for (int i = 0; i < NUM_BOARDS; i++) begin
      board_hot[i] = (32'(board) == i);
    end
  end

  always_comb begin
    st   = state;
    left = payload_left;
    seen = seen_boards;
    hit  = 1'b0;
    dup  = 1'b0;
    oor  = 1'b0;

    unique case (state.phase)
      abwd_pkg::PH_SCAN: begin
        if (found) begin
          st.current_bank       = found_idx;
          st.latest_board       = '0;
          st.latest_board_known = 1'b0;
          st.phase              = abwd_pkg::PH_TYPE;
        end
      end
      abwd_pkg::PH_TYPE: begin
        st.phase = abwd_pkg::PH_SIZE;
      end
      abwd_pkg::PH_SIZE: begin
        // Byte size to words, saturated at the counter's range.
        if ({1'b0, size_words} > CountMax) begin
          left = '1;
        end else begin
          left = size_words[PAYLOAD_COUNT_BITS-1:0];
        end
        st.phase = (size_words == '0) ? abwd_pkg::PH_SCAN : abwd_pkg::PH_PAYLOAD;
      end
      abwd_pkg::PH_PAYLOAD: begin
        case (item.word[31:30])
          abwd_pkg::KIND_HEADER: begin
            st.latest_board       = board;
            st.latest_board_known = 1'b1;
            oor = (32'(board) >= NUM_BOARDS);
            dup = !oor && |(seen_boards & board_hot);
            if (!oor && !dup) begin
              seen = seen_boards | board_hot;
            end
          end
          abwd_pkg::KIND_DATA: begin
            hit = 1'b1;
          end
          default: begin
            // trailer and unknown words carry nothing
          end
        endcase
        left = payload_left - 1'b1;
        if (left == '0) begin
          st.phase = abwd_pkg::PH_SCAN;
        end
      end
      default: begin
        st.phase = abwd_pkg::PH_SCAN;
      end
    endcase
  end

  assign show_bank = hit || dup || oor;
  assign emit      = show_bank || item.last_word;

  always_comb begin
    result                    = '0;
    result.hit_valid          = hit;
    result.bank_index         = show_bank ? st.current_bank : 3'd0;
    result.board_known        = show_bank && st.latest_board_known;
    result.board_id           = (show_bank && st.latest_board_known) ? st.latest_board : 8'd0;
    result.channel            = hit ? item.word[22:18] : 5'd0;
    result.sample_value       = hit ? item.word[7:0] : 8'd0;
    result.event_end          = item.last_word;
    result.boards_complete    = item.last_word && (&seen);
    result.duplicate_board    = dup;
    result.board_out_of_range = oor;
  end

  // The last word closes the event: everything returns to its reset value.
  always_comb begin
    if (item.last_word) begin
      state_next        = '{phase: abwd_pkg::PH_SCAN, current_bank: 3'd0,
                            latest_board: 8'd0, latest_board_known: 1'b0};
      payload_left_next = '0;
      seen_boards_next  = '0;
    end else begin
      state_next        = st;
      payload_left_next = left;
      seen_boards_next  = seen;
    end
  end

endmodule

// ===== rtl/core/abwd_out_reg.sv =====
// ----------------------------------------------------------------------------
// abwd_out_reg
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module abwd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  abwd_pkg::result_t load_data,
  output logic              free,
  output logic              result_valid,
  input  logic              result_ready,
  output abwd_pkg::result_t result_data
);

  logic full;

  // Free when empty or when the held result leaves this cycle.
  assign free         = !full || result_ready;
  assign result_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (result_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_data;
    end
  end

endmodule
